// File: sv/dlav_pkg.sv
// Package for the disklabel locate and verify block: constants, codes, the
// result type and the magic byte lookup. Depends on nothing.
package dlav_pkg;

  localparam int SectorBytesDef = 512;

  localparam logic [31:0] MagicWord    = 32'h8256_4557;
  localparam logic [7:0]  MagicFirstBe = 8'h82;
  localparam logic [7:0]  MagicFirstLe = 8'h57;

  localparam int SecondMagicOfs = 'h84;
  localparam int ChecksumOfs    = 'h88;
  localparam int CountOfs       = 'h8A;
  localparam int HeaderBytes    = 'h94;
  localparam int PartBytes      = 'h10;
  localparam int PartShift      = $clog2(PartBytes);

  // Wide enough for offset plus header plus 16 * 65535 partition bytes.
  localparam int SizeW = 21;

  typedef enum logic [2:0] {
    STAT_NONE    = 3'd0,
    STAT_TRUNC   = 3'd1,
    STAT_BAD     = 3'd2,
    STAT_OK      = 3'd3,
    STAT_RELAXED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CK,
    ST_COUNT_RD,
    ST_COUNT_CK,
    ST_XOR,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    status_e     status;
    logic [8:0]  label_offset;
    logic        big_endian;
    logic [15:0] partition_count;
    logic        checksum_ok;
  } result_t;

  // Byte idx of the magic word as it sits in memory for the given byte order.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx, input logic be);
    logic [7:0] b;
    if (be) begin
      b = MagicWord[8*(3-idx) +: 8];
    end else begin
      b = MagicWord[8*idx +: 8];
    end
    return b;
  endfunction

endpackage

// File: sv/dlav_store.sv
// Sector byte store: one write port and two registered read ports.
// Depends on nothing but its parameter.
module dlav_store #(
  parameter int SectorBytes = 512,
  localparam int AW = $clog2(SectorBytes)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [7:0]    rdata_a_o,
  output logic [7:0]    rdata_b_o
);

  logic [7:0] mem [SectorBytes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// File: sv/dlav_seq.sv
// Sequencer: stores incoming bytes, then scans for the label, reads the
// partition count and XORs the label words. Depends on dlav_pkg.
module dlav_seq #(
  parameter int SectorBytes = 512,
  localparam int AW = $clog2(SectorBytes),
  localparam int CW = $clog2(SectorBytes + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  logic                in_last_i,
  input  logic                relaxed_i,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output dlav_pkg::result_t   res_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [7:0]          mem_wdata_o,
  output logic [AW-1:0]       mem_raddr_a_o,
  output logic [AW-1:0]       mem_raddr_b_o,
  input  logic [7:0]          mem_rdata_a_i,
  input  logic [7:0]          mem_rdata_b_i
);

  localparam int SW = dlav_pkg::SizeW;

  dlav_pkg::seq_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] len_q, len_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [1:0]    j_q, j_d;
  logic          be_q, be_d;
  logic          found_q, found_d;
  logic          trunc_q, trunc_d;
  logic [15:0]   npart_q, npart_d;
  logic [SW-1:0] size_q, size_d;
  logic [SW-1:0] k_q, k_d;
  logic          pend_q, pend_d;
  logic          pend_chk_q, pend_chk_d;
  logic [7:0]    lo_q, lo_d, hi_q, hi_d, slo_q, slo_d, shi_q, shi_d;

  logic          accept;
  logic [CW-1:0] cnt_next;
  logic          long_enough;
  logic          be_cand, le_cand, hit, more;
  logic [7:0]    exp_byte;
  logic [15:0]   npart_c;
  logic [SW-1:0] size_c;
  logic          trunc_c, k_more, ok_c;

  assign in_ready_o = (state_q == dlav_pkg::ST_LOAD);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    cnt_next    = (cnt_q < CW'(SectorBytes)) ? cnt_q + CW'(1) : cnt_q;
    long_enough = SW'(cnt_next) >= SW'(dlav_pkg::HeaderBytes);
    be_cand     = (mem_rdata_a_i == dlav_pkg::MagicFirstBe) &&
                  (mem_rdata_b_i == dlav_pkg::MagicFirstBe);
    le_cand     = (mem_rdata_a_i == dlav_pkg::MagicFirstLe) &&
                  (mem_rdata_b_i == dlav_pkg::MagicFirstLe);
    exp_byte    = dlav_pkg::magic_byte(j_q, be_q);
    hit         = (j_q == 2'd0) ? (be_cand || le_cand)
                                : (mem_rdata_a_i == exp_byte && mem_rdata_b_i == exp_byte);
    more        = SW'(pos_q) + SW'(dlav_pkg::HeaderBytes + 1) <= SW'(len_q);
    npart_c     = be_q ? {mem_rdata_a_i, mem_rdata_b_i} : {mem_rdata_b_i, mem_rdata_a_i};
    size_c      = SW'(dlav_pkg::HeaderBytes) + (SW'(npart_c) << dlav_pkg::PartShift);
    trunc_c     = SW'(pos_q) + size_c > SW'(len_q);
    k_more      = k_q < size_q;
    ok_c        = (lo_q == slo_q) && (hi_q == shi_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dlav_pkg::ST_LOAD: begin
        if (accept && in_last_i) begin
          state_d = long_enough ? dlav_pkg::ST_SCAN_RD : dlav_pkg::ST_FINISH;
        end
      end
      dlav_pkg::ST_SCAN_RD: state_d = dlav_pkg::ST_SCAN_CK;
      dlav_pkg::ST_SCAN_CK: begin
        if (hit) begin
          state_d = (j_q == 2'd3) ? dlav_pkg::ST_COUNT_RD : dlav_pkg::ST_SCAN_RD;
        end else begin
          state_d = more ? dlav_pkg::ST_SCAN_RD : dlav_pkg::ST_FINISH;
        end
      end
      dlav_pkg::ST_COUNT_RD: state_d = dlav_pkg::ST_COUNT_CK;
      dlav_pkg::ST_COUNT_CK: state_d = trunc_c ? dlav_pkg::ST_FINISH : dlav_pkg::ST_XOR;
      dlav_pkg::ST_XOR:      state_d = k_more ? dlav_pkg::ST_XOR : dlav_pkg::ST_FINISH;
      dlav_pkg::ST_FINISH:   state_d = out_free_i ? dlav_pkg::ST_LOAD : dlav_pkg::ST_FINISH;
      default:               state_d = dlav_pkg::ST_LOAD;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_d = cnt_q;  len_d = len_q;  pos_d = pos_q;  j_d = j_q;  be_d = be_q;
    found_d = found_q;  trunc_d = trunc_q;  npart_d = npart_q;  size_d = size_q;
    k_d = k_q;  pend_d = pend_q;  pend_chk_d = pend_chk_q;
    lo_d = lo_q;  hi_d = hi_q;  slo_d = slo_q;  shi_d = shi_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = cnt_q[AW-1:0];
    mem_wdata_o   = in_byte_i;
    mem_raddr_a_o = '0;
    mem_raddr_b_o = '0;
    res_valid_o   = 1'b0;
    res_o         = '0;
    case (state_q)
      dlav_pkg::ST_LOAD: begin
        if (accept) begin
          mem_we_o = (cnt_q < CW'(SectorBytes));
          cnt_d    = cnt_next;
          if (in_last_i) begin
            len_d   = cnt_next;
            cnt_d   = '0;
            pos_d   = '0;
            j_d     = '0;
            found_d = 1'b0;
            trunc_d = 1'b0;
            npart_d = '0;
          end
        end
      end
      dlav_pkg::ST_SCAN_RD: begin
        mem_raddr_a_o = pos_q + AW'(j_q);
        mem_raddr_b_o = pos_q + AW'(dlav_pkg::SecondMagicOfs) + AW'(j_q);
      end
      dlav_pkg::ST_SCAN_CK: begin
        if (hit) begin
          if (j_q == 2'd0) begin
            be_d = be_cand;
          end
          j_d = j_q + 2'd1;
          if (j_q == 2'd3) begin
            found_d = 1'b1;
          end
        end else begin
          j_d = '0;
          if (more) begin
            pos_d = pos_q + AW'(1);
          end
        end
      end
      dlav_pkg::ST_COUNT_RD: begin
        mem_raddr_a_o = pos_q + AW'(dlav_pkg::CountOfs);
        mem_raddr_b_o = pos_q + AW'(dlav_pkg::CountOfs + 1);
      end
      dlav_pkg::ST_COUNT_CK: begin
        npart_d = npart_c;
        size_d  = size_c;
        trunc_d = trunc_c;
        k_d     = '0;
        pend_d  = 1'b0;
        lo_d    = '0;
        hi_d    = '0;
      end
      dlav_pkg::ST_XOR: begin
        // Data read in the previous cycle lands now.
        if (pend_q) begin
          if (pend_chk_q) begin
            slo_d = mem_rdata_a_i;
            shi_d = mem_rdata_b_i;
          end else begin
            lo_d = lo_q ^ mem_rdata_a_i;
            hi_d = hi_q ^ mem_rdata_b_i;
          end
        end
        if (k_more) begin
          mem_raddr_a_o = AW'(SW'(pos_q) + k_q);
          mem_raddr_b_o = AW'(SW'(pos_q) + k_q + SW'(1));
          pend_d        = 1'b1;
          pend_chk_d    = (k_q == SW'(dlav_pkg::ChecksumOfs));
          k_d           = k_q + SW'(2);
        end else begin
          pend_d = 1'b0;
        end
      end
      dlav_pkg::ST_FINISH: begin
        res_valid_o = out_free_i;
        if (found_q) begin
          res_o.label_offset    = 9'(pos_q);
          res_o.big_endian      = be_q;
          res_o.partition_count = npart_q;
          if (trunc_q) begin
            res_o.status = dlav_pkg::STAT_TRUNC;
          end else begin
            res_o.checksum_ok = ok_c;
            if (ok_c) begin
              res_o.status = dlav_pkg::STAT_OK;
            end else if (relaxed_i) begin
              res_o.status = dlav_pkg::STAT_RELAXED;
            end else begin
              res_o.status = dlav_pkg::STAT_BAD;
            end
          end
        end else begin
          res_o.status = dlav_pkg::STAT_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dlav_pkg::ST_LOAD;
      cnt_q      <= '0;
      len_q      <= '0;
      pos_q      <= '0;
      j_q        <= '0;
      be_q       <= 1'b0;
      found_q    <= 1'b0;
      trunc_q    <= 1'b0;
      npart_q    <= '0;
      size_q     <= '0;
      k_q        <= '0;
      pend_q     <= 1'b0;
      pend_chk_q <= 1'b0;
      lo_q       <= '0;
      hi_q       <= '0;
      slo_q      <= '0;
      shi_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      j_q        <= j_d;
      be_q       <= be_d;
      found_q    <= found_d;
      trunc_q    <= trunc_d;
      npart_q    <= npart_d;
      size_q     <= size_d;
      k_q        <= k_d;
      pend_q     <= pend_d;
      pend_chk_q <= pend_chk_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      slo_q      <= slo_d;
      shi_q      <= shi_d;
    end
  end

endmodule

// File: sv/disklabel_locate_and_verify_top.sv
// Top level of the disklabel locate and verify block: sector store,
// sequencer, configuration register and output register.
// Depends on dlav_pkg, dlav_store and dlav_seq.
//
//   Channel   Direction  Signals                         Carries
//   s_axis    in         tvalid tready tdata[7:0] tlast  one sector byte, tlast on the final one
//   m_axis    out        tvalid tready tdata[31:0]       one verdict per sector
//   cfg       in         cfg_we_i cfg_wdata_i            relaxed checksum setting
//
// Sector bytes are taken while the sequencer loads and are written to the sector store.
// After the byte with tlast the sequencer holds s_axis_tready low while it
// works on the store: it checks the magic bytes at each scanned offset,
// reads the partition count, then XORs the label words for the checksum
// over size bytes, where size is 148 + 16 * partition count; the single
// pair of store read ports sets the pace of this work. A finished verdict
// sits in the output register, so the next sector's bytes are taken while it
// waits; a second verdict waits in the sequencer until the register frees.
// Reset clears all control state and the relaxed setting; the store holds
// no meaningful data until bytes are written.
module disklabel_locate_and_verify_top #(
  parameter int SectorBytes = dlav_pkg::SectorBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: relaxed_checksum.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [2:0] status, [11:3] label_offset, [12] big_endian,
                                      // [28:13] partition_count, [29] checksum_ok,
                                      // [31:30] zero
);

  localparam int AW = $clog2(SectorBytes);

  logic              relaxed_q, relaxed_d;
  logic              m_valid_q, m_valid_d;
  logic [31:0]       m_data_q, m_data_d;
  logic              out_free;
  logic              res_valid;
  dlav_pkg::result_t res;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [7:0]        mem_wdata, mem_rdata_a, mem_rdata_b;

  dlav_store #(
    .SectorBytes(SectorBytes)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (mem_wdata),
    .raddr_a_i(mem_raddr_a),
    .raddr_b_i(mem_raddr_b),
    .rdata_a_o(mem_rdata_a),
    .rdata_b_o(mem_rdata_b)
  );

  dlav_seq #(
    .SectorBytes(SectorBytes)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .relaxed_i    (relaxed_q),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_a_o(mem_raddr_a),
    .mem_raddr_b_o(mem_raddr_b),
    .mem_rdata_a_i(mem_rdata_a),
    .mem_rdata_b_i(mem_rdata_b)
  );

  // The output register can take a verdict when empty or being drained.
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    relaxed_d = cfg_we_i ? cfg_wdata_i : relaxed_q;
    m_data_d  = m_data_q;
    if (res_valid) begin
      m_valid_d = 1'b1;
      m_data_d  = {2'b00, res.checksum_ok, res.partition_count, res.big_endian,
                   res.label_offset, res.status};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relaxed_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      relaxed_q <= relaxed_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
